@@ hw/rtl/b64u_pkg.sv @@
// Package: word types, queue entry type and alphabet lookup for the base64url encoder.
package b64u_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_word_t;

  // One decoded byte: one or two alphabet indexes and the end-of-message flag.
  typedef struct packed {
    logic [5:0] idx_first;
    logic [5:0] idx_second;
    logic       has_second;
    logic       last;
  } task_t;

  typedef enum logic [2:0] {
    PhaseZero = 3'b001,
    PhaseOne  = 3'b010,
    PhaseTwo  = 3'b100
  } phase_e;

  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharDash   = 8'h2d;
  localparam logic [7:0] CharUscore = 8'h5f;

  // Map a 6-bit index to its URL-safe alphabet character.
  function automatic logic [7:0] alpha_char(input logic [5:0] idx);
    logic [7:0] wide;
    logic [7:0] ch;
    wide = {2'b00, idx};
    if (idx < 6'd26) begin
      ch = CharUpperA + wide;
    end else if (idx < 6'd52) begin
      ch = CharLowerA + (wide - 8'd26);
    end else if (idx < 6'd62) begin
      ch = CharZero + (wide - 8'd52);
    end else if (idx == 6'd62) begin
      ch = CharDash;
    end else begin
      ch = CharUscore;
    end
    return ch;
  endfunction

endpackage

@@ hw/rtl/b64u_front.sv @@
// Front end: accept bytes, track group phase and leftover bits, issue character indexes.
module b64u_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  b64u_pkg::in_word_t in_word_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output b64u_pkg::task_t    push_task_o
);

  b64u_pkg::phase_e phase_q, phase_d;
  logic [3:0]       left_q, left_d;
  logic [7:0]       b;
  logic             fin;
  logic             accept;

  assign b            = in_word_i.data_byte;
  assign fin          = in_word_i.final_byte;
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i & push_ready_i;

  always_comb begin
    push_task_o.last = fin;
    case (phase_q)
      b64u_pkg::PhaseOne: begin
        push_task_o.idx_first  = {left_q[1:0], b[7:4]};
        push_task_o.idx_second = {2'b00, b[3:0]};
        push_task_o.has_second = fin;
        left_d                 = b[3:0];
        phase_d                = b64u_pkg::PhaseTwo;
      end
      b64u_pkg::PhaseTwo: begin
        push_task_o.idx_first  = {left_q, b[7:6]};
        push_task_o.idx_second = b[5:0];
        push_task_o.has_second = 1'b1;
        left_d                 = 4'd0;
        phase_d                = b64u_pkg::PhaseZero;
      end
      default: begin
        push_task_o.idx_first  = b[7:2];
        push_task_o.idx_second = {4'b0000, b[1:0]};
        push_task_o.has_second = fin;
        left_d                 = {2'b00, b[1:0]};
        phase_d                = b64u_pkg::PhaseOne;
      end
    endcase
    // Drop group state at the end of a message.
    if (fin) begin
      left_d  = 4'd0;
      phase_d = b64u_pkg::PhaseZero;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= b64u_pkg::PhaseZero;
      left_q  <= 4'd0;
    end else if (accept) begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

endmodule

@@ hw/rtl/b64u_queue.sv @@
// Short task queue between the front end and the character emitter.
module b64u_queue #(
  parameter int unsigned Depth = b64u_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  b64u_pkg::task_t push_task_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output b64u_pkg::task_t pop_task_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  b64u_pkg::task_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != FullCnt);
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_task_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_task_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

@@ hw/rtl/b64u_back.sv @@
// Back end: emit one alphabet character per cycle, unless stalled, from queued tasks into an output register.
module b64u_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  b64u_pkg::task_t     pop_task_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output b64u_pkg::out_word_t out_word_o
);

  logic                second_q, second_d;
  logic                out_valid_q, out_valid_d;
  b64u_pkg::out_word_t out_q, out_d;
  logic                load;
  logic [5:0]          idx;

  assign load = pop_valid_i & (~out_valid_q | out_ready_i);
  assign idx  = second_q ? pop_task_i.idx_second : pop_task_i.idx_first;

  always_comb begin
    out_d.out_char  = b64u_pkg::alpha_char(idx);
    out_d.last_char = pop_task_i.last & (second_q | ~pop_task_i.has_second);
    // Retire the task once its final character is loaded.
    pop_ready_o = load & (second_q | ~pop_task_i.has_second);
    second_d    = second_q;
    if (load) begin
      second_d = ~second_q & pop_task_i.has_second;
    end
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      second_q    <= second_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

@@ hw/rtl/base64url_stream_encoder.sv @@
// Top level: unpadded base64url stream encoder, one byte in and one character out per word.
//
//   channel | direction | handshake             | word
//   --------+-----------+-----------------------+------------------------------------
//   in      | input     | in_valid_i/in_ready_o  | in_word_i  {data_byte, final_byte}
//   out     | output    | out_valid_o/out_ready_i| out_word_o {out_char, last_char}
//
// The output emits one character per cycle unless stalled. A byte yields one character,
// or two when it closes a 3-byte group or ends the message; the front end takes a byte
// per cycle while the queue has room. An accepted byte passes through a queue write and
// then the output register before its first character appears.
// Reset clears the group phase, the leftover bits, the queue and the output valid.
// An output stall fills the queue and then drops in_ready_o; each side stalls alone.
module base64url_stream_encoder #(
  parameter int unsigned QueueDepth = b64u_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  b64u_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output b64u_pkg::out_word_t out_word_o
);

  // Front end to queue.
  logic            push_valid;
  logic            push_ready;
  b64u_pkg::task_t push_task;

  // Queue to back end.
  logic            pop_valid;
  logic            pop_ready;
  b64u_pkg::task_t pop_task;

  // Classify each byte by its place in the group and form the alphabet indexes.
  b64u_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_word_i    (in_word_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_task_o  (push_task)
  );

  // Hold decoded tasks while the output side stalls.
  b64u_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_task_i  (push_task),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_task_o   (pop_task)
  );

  // Advance one character per cycle, unless the output stalls, into the output register.
  b64u_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_task_i  (pop_task),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

@@ tb/tb.sv @@
// Testbench for the unpadded base64url stream encoder: predictor, scoreboard, stimulus.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Stop the stimulus after this many random bytes; a stuck handshake hits the
  // cycle limit.
  localparam int unsigned RandomBytes = 1750;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 8;

  // One row of the directed table. When n_typed is nonzero, the expected characters
  // are typed in here; otherwise the predictor supplies them.
  typedef struct packed {
    b64u_pkg::in_word_t  w;
    logic [1:0]          n_typed;
    b64u_pkg::out_word_t t0;
    b64u_pkg::out_word_t t1;
  } dir_row_t;

  localparam int unsigned NumDirRows = 22;

  localparam dir_row_t DirRows [NumDirRows] = '{
    // Single-byte messages at both extremes.
    '{'{8'h00, 1'b1}, 2'd2, '{"A", 1'b0}, '{"A", 1'b1}},
    '{'{8'hff, 1'b1}, 2'd2, '{"_", 1'b0}, '{"D", 1'b1}},
    // Full group of all ones: every index lands on the top of the alphabet.
    '{'{8'hff, 1'b0}, 2'd1, '{"_", 1'b0}, '{"A", 1'b0}},
    '{'{8'hff, 1'b0}, 2'd1, '{"_", 1'b0}, '{"A", 1'b0}},
    '{'{8'hff, 1'b1}, 2'd2, '{"_", 1'b0}, '{"_", 1'b1}},
    // Full group ending on the dash character.
    '{'{8'h00, 1'b0}, 2'd1, '{"A", 1'b0}, '{"A", 1'b0}},
    '{'{8'h00, 1'b0}, 2'd1, '{"A", 1'b0}, '{"A", 1'b0}},
    '{'{8'hfe, 1'b1}, 2'd2, '{"D", 1'b0}, '{"-", 1'b1}},
    // Two-byte message: the four-bit tail stays right-aligned.
    '{'{8'h00, 1'b0}, 2'd1, '{"A", 1'b0}, '{"A", 1'b0}},
    '{'{8'hff, 1'b1}, 2'd2, '{"P", 1'b0}, '{"P", 1'b1}},
    // Plain text group.
    '{'{8'h4d, 1'b0}, 2'd0, '{"A", 1'b0}, '{"A", 1'b0}},
    '{'{8'h61, 1'b0}, 2'd0, '{"A", 1'b0}, '{"A", 1'b0}},
    '{'{8'h6e, 1'b1}, 2'd0, '{"A", 1'b0}, '{"A", 1'b0}},
    // Group closes without an end, then a one-byte tail.
    '{'{8'haa, 1'b0}, 2'd0, '{"A", 1'b0}, '{"A", 1'b0}},
    '{'{8'h55, 1'b0}, 2'd0, '{"A", 1'b0}, '{"A", 1'b0}},
    '{'{8'haa, 1'b0}, 2'd0, '{"A", 1'b0}, '{"A", 1'b0}},
    '{'{8'h55, 1'b1}, 2'd0, '{"A", 1'b0}, '{"A", 1'b0}},
    // Two-byte tail with leftover bits set.
    '{'{8'hfe, 1'b0}, 2'd0, '{"A", 1'b0}, '{"A", 1'b0}},
    '{'{8'h01, 1'b1}, 2'd0, '{"A", 1'b0}, '{"A", 1'b0}},
    // Three-byte message with one, seven and one bits set.
    '{'{8'h80, 1'b0}, 2'd0, '{"A", 1'b0}, '{"A", 1'b0}},
    '{'{8'h7f, 1'b0}, 2'd0, '{"A", 1'b0}, '{"A", 1'b0}},
    '{'{8'h01, 1'b1}, 2'd0, '{"A", 1'b0}, '{"A", 1'b0}}
  };

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  b64u_pkg::in_word_t  in_word_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  b64u_pkg::out_word_t out_word_o;

  base64url_stream_encoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: group phase and the leftover bits of the previous byte.
  // ---------------------------------------------------------------------------
  string            url_alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
  b64u_pkg::phase_e grp_phase  = b64u_pkg::PhaseZero;
  logic [3:0]       carry_bits = '0;

  // Characters still owed by the encoder, oldest first.
  b64u_pkg::out_word_t pending_chars [$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned burst_left     = 0;

  function automatic b64u_pkg::out_word_t url_char(input logic [5:0] idx,
                                                   input logic last);
    b64u_pkg::out_word_t c;
    c.out_char  = url_alphabet[idx];
    c.last_char = last;
    return c;
  endfunction

  // Encode one byte into one or two characters and advance the group state.
  // A tail uses the leftover bits as a right-aligned index, with no left shift.
  function automatic int unsigned encode_byte(input b64u_pkg::in_word_t w,
                                              output b64u_pkg::out_word_t c0,
                                              output b64u_pkg::out_word_t c1);
    logic [7:0]  b;
    int unsigned n;
    b  = w.data_byte;
    c1 = '0;
    case (grp_phase)
      b64u_pkg::PhaseOne: begin
        c0 = url_char({carry_bits[1:0], b[7:4]}, 1'b0);
        c1 = url_char({2'b00, b[3:0]}, 1'b1);
        n  = w.final_byte ? 2 : 1;
        carry_bits = b[3:0];
        grp_phase  = b64u_pkg::PhaseTwo;
      end
      b64u_pkg::PhaseTwo: begin
        c0 = url_char({carry_bits, b[7:6]}, 1'b0);
        c1 = url_char(b[5:0], w.final_byte);
        n  = 2;
        carry_bits = '0;
        grp_phase  = b64u_pkg::PhaseZero;
      end
      default: begin
        // Any phase value outside the group acts as the start of a group.
        c0 = url_char(b[7:2], 1'b0);
        c1 = url_char({4'b0000, b[1:0]}, 1'b1);
        n  = w.final_byte ? 2 : 1;
        carry_bits = {2'b00, b[1:0]};
        grp_phase  = b64u_pkg::PhaseOne;
      end
    endcase
    // End of message: start the next one from a clean group.
    if (w.final_byte) begin
      grp_phase  = b64u_pkg::PhaseZero;
      carry_bits = '0;
    end
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: drive one word, hold it until accepted, then queue its characters.
  // Bursts of random length alternate with random gaps; some gaps are zero so
  // that long stretches run back to back.
  // ---------------------------------------------------------------------------
  task automatic send_word(input b64u_pkg::in_word_t w, input logic [1:0] n_typed,
                           input b64u_pkg::out_word_t t0,
                           input b64u_pkg::out_word_t t1);
    int unsigned         gap;
    int unsigned         n;
    b64u_pkg::out_word_t c0;
    b64u_pkg::out_word_t c1;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    // Hold valid and the word until the encoder takes it.
    do @(posedge clk_i); while (!in_ready_o);
    n = encode_byte(w, c0, c1);
    if (n_typed != 0) begin
      pending_chars.push_back(t0);
      if (n_typed == 2) pending_chars.push_back(t1);
    end else begin
      pending_chars.push_back(c0);
      if (n == 2) pending_chars.push_back(c1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall on a mask that changes whenever the low byte of the cycle counter
  // wraps, from always ready to mostly stalled. Check every accepted character against the oldest one owed.
  // ---------------------------------------------------------------------------
  logic [7:0] stall_mask = 8'hff;

  always @(posedge clk_i) begin
    b64u_pkg::out_word_t want;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt[7:0] == 8'd0) begin
      case ($urandom_range(0, 3))
        0:       stall_mask <= 8'hff;
        1:       stall_mask <= 8'h01 << $urandom_range(0, 7);
        default: stall_mask <= 8'($urandom_range(0, 255));
      endcase
    end
    out_ready_i <= stall_mask[cycle_cnt[2:0]];

    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_chars.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected word, expected none, actual char %h last %b",
                 $time, out_word_o.out_char, out_word_o.last_char);
      end else begin
        want = pending_chars.pop_front();
        if (out_word_o.out_char !== want.out_char) begin
          mismatch_count++;
          $display("%0t: out_char mismatch, expected %h actual %h",
                   $time, want.out_char, out_word_o.out_char);
        end
        if (out_word_o.last_char !== want.last_char) begin
          mismatch_count++;
          $display("%0t: last_char mismatch, expected %b actual %b",
                   $time, want.last_char, out_word_o.last_char);
        end
      end
    end

    if (cycle_cnt == CycleLimit) begin
      $display("tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, random messages, drain.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned        sent_bytes;
    int unsigned        msg_len;
    b64u_pkg::in_word_t w;
    sent_bytes = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirRows; i++) begin
      send_word(DirRows[i].w, DirRows[i].n_typed, DirRows[i].t0, DirRows[i].t1);
    end

    // Random messages; weight the short lengths so every tail shape comes up often.
    while (sent_bytes < RandomBytes) begin
      case ($urandom_range(0, 5))
        0:       msg_len = 1;
        1:       msg_len = 2;
        2:       msg_len = 3;
        default: msg_len = $urandom_range(4, 24);
      endcase
      for (int k = 0; k < msg_len; k++) begin
        if ($urandom_range(0, 15) == 0) begin
          w.data_byte = $urandom_range(0, 1) ? 8'hff : 8'h00;
        end else begin
          w.data_byte = 8'($urandom_range(0, 255));
        end
        w.final_byte = (k == msg_len - 1);
        send_word(w, 2'd0, '0, '0);
        sent_bytes++;
      end
    end
    in_valid_i <= 1'b0;

    // Drain: wait for every owed character, then watch for strays.
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0 && pending_chars.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
